[hw/rtl/r250_pkg.sv]
// Shared constants, types and index helpers for the R250 generator.
package r250_pkg;

  localparam int unsigned LAG_LEN    = 250;
  localparam int unsigned LAG_TAP    = 103;
  localparam int unsigned LAG_SPLIT  = LAG_LEN - LAG_TAP;
  localparam int unsigned WARM_STEPS = LAG_LEN * LAG_LEN;
  localparam int unsigned MASK_WORDS = 16;
  localparam int unsigned MASK_STEP  = 11;
  localparam int unsigned MASK_FIRST = 3;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned SEED_W  = 32;
  localparam int unsigned IDX_W   = $clog2(LAG_LEN);
  localparam int unsigned WARM_W  = $clog2(WARM_STEPS);
  localparam int unsigned MCNT_W  = $clog2(MASK_WORDS + 1);

  localparam logic [SEED_W-1:0] LCG_MUL = 32'd214013;
  localparam logic [SEED_W-1:0] LCG_ADD = 32'd2531011;
  localparam logic [WORD_W-1:0] TOP_BIT = 16'h8000;
  localparam logic [WORD_W-1:0] ALL_ONES = 16'hFFFF;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic signed [SEED_W-1:0] seed_t;
  typedef logic [IDX_W-1:0] idx_t;

  // Tap partner of a position: 103 places ahead, modulo the store length.
  function automatic idx_t partner_of(input idx_t p);
    if (p >= IDX_W'(LAG_SPLIT)) begin
      partner_of = p - IDX_W'(LAG_SPLIT);
    end else begin
      partner_of = p + IDX_W'(LAG_TAP);
    end
  endfunction

  function automatic idx_t next_pos(input idx_t p);
    if (p >= IDX_W'(LAG_LEN - 1)) begin
      next_pos = '0;
    end else begin
      next_pos = p + 1'b1;
    end
  endfunction

endpackage

[hw/rtl/r250_random_generator_unit.sv]
// R250 lagged-Fibonacci XOR generator: lag memory, seeding LCG and control FSM.
//
// Generate beat: the FSM steps through S_RD (read) and S_WR (XOR/write-back),
//   then registers the result strobe; no new request is taken until idle again.
// Seed beat: 250 fill words (one LCG word per cycle into the lag memory) then
//   62500 warm-up steps through the same read/write path; out_valid strobes
//   with seed_done set after the last step, and the next beat is taken in idle.
// The receiver cannot stall: each result is flagged on out_valid for one cycle only.
// Reset (rst_n low, synchronous) idles the FSM and zeroes the position; the
//   lag memory keeps no reset and is undefined until the first seed beat.
module r250_random_generator_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_cmd,
  input  r250_pkg::seed_t     in_seed_value,
  output logic                out_valid,
  output r250_pkg::word_t     out_random_value,
  output logic                out_seed_done
);
  import r250_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_RD,
    S_WR
  } state_t;

  state_t               state_r;
  idx_t                 pos_r;
  logic                 warming_r;
  logic [WARM_W-1:0]    warm_r;
  logic [SEED_W-1:0]    lcg_r;
  idx_t                 fill_r;
  logic [MCNT_W-1:0]    mcnt_r;
  idx_t                 mtarget_r;
  logic                 out_valid_r;
  word_t                out_value_r;
  logic                 out_seed_done_r;

  // Lag memory: one write port, two registered read ports.
  word_t                mem [LAG_LEN];
  word_t                rd_a_r;
  word_t                rd_b_r;
  logic                 mem_we;
  idx_t                 mem_waddr;
  word_t                mem_wdata;

  logic [SEED_W-1:0]    lcg_nxt;
  word_t                fill_word;
  word_t                gen_word;
  logic                 mask_hit;
  logic [3:0]           mask_sh;

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_random_value = out_value_r;
  assign out_seed_done    = out_seed_done_r;

  // One LCG step per fill cycle: the top half of the new value is the word, masked on hit positions.
  assign lcg_nxt  = lcg_r * LCG_MUL + LCG_ADD;
  assign mask_hit = (mcnt_r < MCNT_W'(MASK_WORDS)) && (fill_r == mtarget_r);
  assign mask_sh  = mcnt_r[3:0];

  always_comb begin
    fill_word = lcg_nxt[SEED_W-1 -: WORD_W];
    if (mask_hit) begin
      fill_word = (fill_word & (ALL_ONES >> mask_sh)) | (TOP_BIT >> mask_sh);
    end
  end

  assign gen_word = rd_a_r ^ rd_b_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_r;
    mem_wdata = gen_word;
    case (state_r)
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_r;
        mem_wdata = fill_word;
      end
      S_WR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Reads always address the current position and its partner; the data
  // is used only in S_WR, the cycle after the S_RD issue.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_a_r <= mem[pos_r];
    rd_b_r <= mem[partner_of(pos_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      pos_r           <= '0;
      warming_r       <= 1'b0;
      warm_r          <= '0;
      fill_r          <= '0;
      mcnt_r          <= '0;
      mtarget_r       <= IDX_W'(MASK_FIRST);
      out_valid_r     <= 1'b0;
      out_seed_done_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            if (in_cmd) begin
              lcg_r     <= in_seed_value;
              fill_r    <= '0;
              mcnt_r    <= '0;
              mtarget_r <= IDX_W'(MASK_FIRST);
              state_r   <= S_FILL;
            end else begin
              warming_r <= 1'b0;
              state_r   <= S_RD;
            end
          end
        end
        S_FILL: begin
          lcg_r  <= lcg_nxt;
          fill_r <= fill_r + 1'b1;
          if (mask_hit) begin
            mcnt_r    <= mcnt_r + 1'b1;
            mtarget_r <= mtarget_r + IDX_W'(MASK_STEP);
          end
          if (fill_r == IDX_W'(LAG_LEN - 1)) begin
            pos_r     <= '0;
            warm_r    <= '0;
            warming_r <= 1'b1;
            state_r   <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_WR;
        end
        S_WR: begin
          pos_r <= next_pos(pos_r);
          if (!warming_r) begin
            out_valid_r     <= 1'b1;
            out_value_r     <= gen_word;
            out_seed_done_r <= 1'b0;
            state_r         <= S_IDLE;
          end else if (warm_r == WARM_W'(WARM_STEPS - 1)) begin
            // last discarded step: acknowledge the reseed
            out_valid_r     <= 1'b1;
            out_value_r     <= '0;
            out_seed_done_r <= 1'b1;
            warming_r       <= 1'b0;
            state_r         <= S_IDLE;
          end else begin
            warm_r  <= warm_r + 1'b1;
            state_r <= S_RD;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < IDX_W'(LAG_LEN))
    else $error("position left the lag range");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while busy");

  a_seed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_seed_done_r) |-> (out_value_r == '0))
    else $error("seed acknowledge carries nonzero value");

  a_gen_path: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_cmd) |=> (state_r == S_RD) ##1 (state_r == S_WR)
      ##1 (out_valid_r && !out_seed_done_r))
    else $error("generate beat did not follow read/write/result");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

endmodule
